// ----- src/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");

`endif

// ----- src/ctwa_pkg.sv -----
`default_nettype none
package ctwa_pkg;
   localparam int Capacity = 64;
   localparam int AgeBits  = 8;
   localparam int IdxW     = $clog2(Capacity);
   localparam int CntW     = $clog2(Capacity + 1);
   localparam logic [AgeBits-1:0] AgeMax = {AgeBits{1'b1}};

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_OBSERVE = 2'd1,
      MODE_READ    = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OUT_RANGE = 3'd0,
      ST_REFRESHED = 3'd1,
      ST_INSERTED  = 3'd2,
      ST_DROPPED   = 3'd3,
      ST_TICK_DONE = 3'd4,
      ST_READ_OK   = 3'd5,
      ST_READ_EMPTY = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      CSR_PORT_LOW  = 2'd0,
      CSR_PORT_HIGH = 2'd1,
      CSR_MAX       = 2'd2,
      CSR_AGE       = 2'd3
   } csr_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_WAIT, S_CHECK, S_DONE
   } state_type;

   typedef struct packed {
      logic [31:0] la;
      logic [15:0] lp;
      logic [31:0] ra;
      logic [15:0] rp;
   } tuple_type;
endpackage
`default_nettype wire

// ----- src/connection_table_with_aging.sv -----
// Connection table with aging. Raise start while busy is low to issue one item;
// exactly one result follows with rsp_valid high for one cycle, which cannot
// be stalled. Tick and observe scan held entries through one registered
// memory read port and one compare unit. Reads pass through the wait and
// check states; out-of-range observes and the unused mode go straight to
// the done state. busy stays high through the result cycle, so the next
// item is accepted in the cycle after it at the earliest. Table storage
// needs no clearing at reset.
`default_nettype none
module connection_table_with_aging (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_mode,
   input  wire logic [31:0] req_local_address,
   input  wire logic [15:0] req_local_port_number,
   input  wire logic [31:0] req_remote_address,
   input  wire logic [15:0] req_remote_port_number,
   input  wire logic [5:0]  req_entry_index,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [6:0]       rsp_entry_count,
   output logic [31:0]      rsp_out_local_address,
   output logic [15:0]      rsp_out_local_port,
   output logic [31:0]      rsp_out_remote_address,
   output logic [15:0]      rsp_out_remote_port
);
   localparam int IW = ctwa_pkg::IdxW;
   localparam int CW = ctwa_pkg::CntW;
   localparam int AW = ctwa_pkg::AgeBits;

   logic [15:0] low_ff, high_ff;
   logic [6:0]  max_ff, age_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff <= 16'd0;
         high_ff <= 16'hFFFF;
         max_ff <= 7'd64;
         age_cfg_ff <= 7'd1;
      end else if (csr_write) begin
         unique case (ctwa_pkg::csr_type'(csr_index))
            ctwa_pkg::CSR_PORT_LOW:  low_ff <= csr_data;
            ctwa_pkg::CSR_PORT_HIGH: high_ff <= csr_data;
            ctwa_pkg::CSR_MAX:       max_ff <= csr_data[6:0];
            ctwa_pkg::CSR_AGE:       age_cfg_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // saturated load age and effective limit
   logic [AW-1:0] load_age;
   logic [CW-1:0] limit;
   always_comb begin
      if (32'(age_cfg_ff) > 32'(ctwa_pkg::AgeMax)) load_age = ctwa_pkg::AgeMax;
      else load_age = AW'(age_cfg_ff);
      if (32'(max_ff) < ctwa_pkg::Capacity) limit = CW'(max_ff);
      else limit = CW'(ctwa_pkg::Capacity);
   end

   logic req_out_range;
   assign req_out_range = (req_local_port_number < low_ff) ||
                          (req_local_port_number > high_ff);

   // table memories
   ctwa_pkg::tuple_type tup_mem [ctwa_pkg::Capacity];
   logic [AW-1:0]       age_mem [ctwa_pkg::Capacity];
   ctwa_pkg::tuple_type tup_rd_ff;
   logic [AW-1:0]       age_rd_ff;
   logic [IW-1:0]       rd_addr, wr_addr;
   logic                tup_we, age_we;
   ctwa_pkg::tuple_type tup_wd;
   logic [AW-1:0]       age_wd;

   always_ff @(posedge clock) begin
      if (tup_we) tup_mem[wr_addr] <= tup_wd;
      if (age_we) age_mem[wr_addr] <= age_wd;
      tup_rd_ff <= tup_mem[rd_addr];
      age_rd_ff <= age_mem[rd_addr];
   end

   ctwa_pkg::state_type state_ff, state_in;
   ctwa_pkg::mode_type  mode_ff, mode_in;
   ctwa_pkg::tuple_type key_ff, key_in;
   logic [5:0]    ridx_ff, ridx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] src_ff, src_in;   // scan pointer, issued read address
   logic [CW-1:0] dst_ff, dst_in;   // compaction write pointer
   logic [IW-1:0] chk_ff, chk_in;   // index of data in read register
   logic          vld_ff, vld_in;   // read register holds a scanned entry
   logic [2:0]    st_ff, st_in;
   ctwa_pkg::tuple_type otup_ff, otup_in;
   logic          rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ctwa_pkg::S_IDLE;
         count_ff <= '0;
         rsp_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_ff <= rsp_in;
      end
      mode_ff <= mode_in;
      key_ff <= key_in;
      ridx_ff <= ridx_in;
      src_ff <= src_in;
      dst_ff <= dst_in;
      chk_ff <= chk_in;
      vld_ff <= vld_in;
      st_ff <= st_in;
      otup_ff <= otup_in;
   end

   logic hit;
   assign hit = (tup_rd_ff == key_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ctwa_pkg::S_IDLE: if (start && !busy) begin
            unique case (ctwa_pkg::mode_type'(req_mode))
               ctwa_pkg::MODE_TICK: state_in = ctwa_pkg::S_SCAN;
               ctwa_pkg::MODE_OBSERVE: begin
                  if (req_out_range) state_in = ctwa_pkg::S_DONE;
                  else state_in = ctwa_pkg::S_SCAN;
               end
               ctwa_pkg::MODE_READ: state_in = ctwa_pkg::S_WAIT;
               default: state_in = ctwa_pkg::S_DONE;
            endcase
         end
         ctwa_pkg::S_SCAN: begin
            if (mode_ff == ctwa_pkg::MODE_OBSERVE && vld_ff && hit) state_in = ctwa_pkg::S_DONE;
            else if (src_ff >= count_ff && !vld_ff) state_in = ctwa_pkg::S_DONE;
         end
         ctwa_pkg::S_WAIT:  state_in = ctwa_pkg::S_CHECK;
         ctwa_pkg::S_CHECK: state_in = ctwa_pkg::S_DONE;
         ctwa_pkg::S_DONE:  state_in = ctwa_pkg::S_IDLE;
         default: state_in = ctwa_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mode_in = mode_ff;
      key_in = key_ff;
      ridx_in = ridx_ff;
      count_in = count_ff;
      src_in = src_ff;
      dst_in = dst_ff;
      chk_in = chk_ff;
      vld_in = 1'b0;
      st_in = st_ff;
      otup_in = otup_ff;
      rsp_in = 1'b0;
      rd_addr = src_ff[IW-1:0];
      wr_addr = dst_ff[IW-1:0];
      tup_we = 1'b0;
      age_we = 1'b0;
      tup_wd = tup_rd_ff;
      age_wd = age_rd_ff - AW'(1);
      unique case (state_ff)
         ctwa_pkg::S_IDLE: begin
            mode_in = ctwa_pkg::mode_type'(req_mode);
            key_in = '{la: req_local_address, lp: req_local_port_number,
                       ra: req_remote_address, rp: req_remote_port_number};
            ridx_in = req_entry_index;
            src_in = '0;
            dst_in = '0;
            otup_in = '0;
            st_in = ctwa_pkg::ST_OUT_RANGE;
            if (start && ctwa_pkg::mode_type'(req_mode) == ctwa_pkg::MODE_OBSERVE &&
                req_out_range)
               mode_in = ctwa_pkg::MODE_NONE;
            rd_addr = req_entry_index[IW-1:0];
         end
         ctwa_pkg::S_SCAN: begin
            if (src_ff < count_ff) begin
               vld_in = 1'b1;
               chk_in = src_ff[IW-1:0];
               src_in = src_ff + CW'(1);
            end
            if (mode_ff == ctwa_pkg::MODE_TICK) begin
               st_in = ctwa_pkg::ST_TICK_DONE;
               if (vld_ff && age_rd_ff != '0) begin
                  tup_we = 1'b1;
                  age_we = 1'b1;
                  dst_in = dst_ff + CW'(1);
               end
               if (src_ff >= count_ff && !vld_ff) count_in = dst_ff;
            end else begin
               if (vld_ff && hit) begin
                  wr_addr = chk_ff;
                  age_we = 1'b1;
                  age_wd = load_age;
                  st_in = ctwa_pkg::ST_REFRESHED;
               end else if (src_ff >= count_ff && !vld_ff) begin
                  wr_addr = count_ff[IW-1:0];
                  if (count_ff >= limit) st_in = ctwa_pkg::ST_DROPPED;
                  else begin
                     tup_we = 1'b1;
                     age_we = 1'b1;
                     tup_wd = key_ff;
                     age_wd = load_age;
                     count_in = count_ff + CW'(1);
                     st_in = ctwa_pkg::ST_INSERTED;
                  end
               end
            end
         end
         ctwa_pkg::S_WAIT: rd_addr = ridx_ff[IW-1:0];
         ctwa_pkg::S_CHECK: begin
            if (CW'(ridx_ff) < count_ff) begin
               st_in = ctwa_pkg::ST_READ_OK;
               otup_in = tup_rd_ff;
            end else st_in = ctwa_pkg::ST_READ_EMPTY;
         end
         ctwa_pkg::S_DONE: rsp_in = 1'b1;
         default: ;
      endcase
   end

   assign busy = (state_ff != ctwa_pkg::S_IDLE) || rsp_ff;
   assign rsp_valid = rsp_ff;
   assign rsp_status = st_ff;
   assign rsp_entry_count = 7'(count_ff);
   assign rsp_out_local_address = otup_ff.la;
   assign rsp_out_local_port = otup_ff.lp;
   assign rsp_out_remote_address = otup_ff.ra;
   assign rsp_out_remote_port = otup_ff.rp;
endmodule
`default_nettype wire

// ----- src/ctwa_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module ctwa_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic [2:0] rsp_status,
   input wire logic [6:0] rsp_entry_count
);
   logic take;
   assign take = start && !busy;
   `ASSERT_NEXT(a_busy_after_take, clock, reset, take, busy)
   `ASSERT_IMP(a_rsp_busy, clock, reset, rsp_valid, busy)
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `ASSERT_IMP(a_count_max, clock, reset, rsp_valid, rsp_entry_count <= 7'd64)
   `ASSERT_IMP(a_status_code, clock, reset, rsp_valid, rsp_status != 3'd7)
endmodule
bind connection_table_with_aging ctwa_checker u_ctwa_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status),
   .rsp_entry_count(rsp_entry_count)
);
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
   localparam int HangLimit = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_mode = '0;
   logic [31:0] req_local_address = '0;
   logic [15:0] req_local_port_number = '0;
   logic [31:0] req_remote_address = '0;
   logic [15:0] req_remote_port_number = '0;
   logic [5:0]  req_entry_index = '0;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [6:0]  rsp_entry_count;
   logic [31:0] rsp_out_local_address;
   logic [15:0] rsp_out_local_port;
   logic [31:0] rsp_out_remote_address;
   logic [15:0] rsp_out_remote_port;

   connection_table_with_aging dut (.*);

   always #2 clock = ~clock;

   typedef struct packed {
      ctwa_pkg::status_type status;
      logic [6:0]           count;
      ctwa_pkg::tuple_type  tup;
   } answer_type;

   // mirror of the table
   ctwa_pkg::tuple_type          conn_tuple [ctwa_pkg::Capacity];
   logic [ctwa_pkg::AgeBits-1:0] conn_age [ctwa_pkg::Capacity];
   int unsigned     conn_count;
   logic [15:0]     port_low, port_high;
   logic [6:0]      entry_cap, age_reload;

   answer_type  pending_answers[$];
   int unsigned errors, beats, answers_seen, idle_cycles;
   int unsigned idle_pct;
   int unsigned hits, inserts, drops, expired;

   function automatic answer_type table_step(ctwa_pkg::mode_type mode,
                                             ctwa_pkg::tuple_type t,
                                             logic [5:0] idx);
      answer_type a;
      int unsigned dst, lim;
      logic [ctwa_pkg::AgeBits-1:0] load;
      bit found;
      a = '0;
      found = 0;
      load = (age_reload > ctwa_pkg::AgeMax) ? ctwa_pkg::AgeMax
                                             : ctwa_pkg::AgeBits'(age_reload);
      lim = (entry_cap < ctwa_pkg::Capacity) ? entry_cap : ctwa_pkg::Capacity;
      case (mode)
         ctwa_pkg::MODE_TICK: begin
            dst = 0;
            for (int s = 0; s < conn_count; s++) begin
               if (conn_age[s] == 0) begin
                  expired++;
                  continue;
               end
               conn_tuple[dst] = conn_tuple[s];
               conn_age[dst] = conn_age[s] - 1'b1;
               dst++;
            end
            conn_count = dst;
            a.status = ctwa_pkg::ST_TICK_DONE;
         end
         ctwa_pkg::MODE_OBSERVE: begin
            if (t.lp < port_low || t.lp > port_high) begin
               a.status = ctwa_pkg::ST_OUT_RANGE;
            end else begin
               for (int i = 0; i < conn_count && !found; i++)
                  if (conn_tuple[i] == t) begin
                     conn_age[i] = load;
                     found = 1;
                  end
               if (found) begin
                  a.status = ctwa_pkg::ST_REFRESHED;
                  hits++;
               end else if (conn_count >= lim) begin
                  a.status = ctwa_pkg::ST_DROPPED;
                  drops++;
               end else begin
                  conn_tuple[conn_count] = t;
                  conn_age[conn_count] = load;
                  conn_count++;
                  a.status = ctwa_pkg::ST_INSERTED;
                  inserts++;
               end
            end
         end
         ctwa_pkg::MODE_READ: begin
            if (idx < conn_count) begin
               a.status = ctwa_pkg::ST_READ_OK;
               a.tup = conn_tuple[idx];
            end else begin
               a.status = ctwa_pkg::ST_READ_EMPTY;
            end
         end
         default: a.status = ctwa_pkg::ST_OUT_RANGE;
      endcase
      a.count = 7'(conn_count);
      return a;
   endfunction

   // result checker
   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid) begin
         answers_seen++;
         if (pending_answers.size() == 0) begin
            $error("result beat with nothing expected: status %0d", rsp_status);
            errors++;
         end else begin
            e = pending_answers.pop_front();
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status); errors++;
            end
            if (rsp_entry_count !== e.count) begin
               $error("entry_count exp %0d got %0d", e.count, rsp_entry_count);
               errors++;
            end
            if (rsp_out_local_address !== e.tup.la) begin
               $error("out_local_address exp %h got %h", e.tup.la, rsp_out_local_address);
               errors++;
            end
            if (rsp_out_local_port !== e.tup.lp) begin
               $error("out_local_port exp %h got %h", e.tup.lp, rsp_out_local_port);
               errors++;
            end
            if (rsp_out_remote_address !== e.tup.ra) begin
               $error("out_remote_address exp %h got %h", e.tup.ra, rsp_out_remote_address);
               errors++;
            end
            if (rsp_out_remote_port !== e.tup.rp) begin
               $error("out_remote_port exp %h got %h", e.tup.rp, rsp_out_remote_port);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no beat in either direction
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HangLimit) begin
         $display("timeout: no beat for %0d cycles", HangLimit);
         $display("** connection_table_with_aging: FAILED **");
         $finish;
      end
   end

   // start stays high after a beat unless the sender idles; drain lowers it
   task automatic send_item(ctwa_pkg::mode_type mode, ctwa_pkg::tuple_type t,
                            logic [5:0] idx);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      start <= 1'b1;
      req_mode <= mode;
      req_local_address <= t.la;
      req_local_port_number <= t.lp;
      req_remote_address <= t.ra;
      req_remote_port_number <= t.rp;
      req_entry_index <= idx;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_answers.push_back(table_step(mode, t, idx));
      beats++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(ctwa_pkg::csr_type idx, logic [15:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         ctwa_pkg::CSR_PORT_LOW:  port_low = val;
         ctwa_pkg::CSR_PORT_HIGH: port_high = val;
         ctwa_pkg::CSR_MAX:       entry_cap = val[6:0];
         default:                 age_reload = val[6:0];
      endcase
      @(posedge clock);
   endtask

   function automatic ctwa_pkg::tuple_type rand_tuple();
      ctwa_pkg::tuple_type t;
      t.la = $urandom;
      t.lp = 16'($urandom);
      t.ra = $urandom;
      t.rp = 16'($urandom);
      return t;
   endfunction

   function automatic ctwa_pkg::tuple_type pool_tuple(int k);
      ctwa_pkg::tuple_type t;
      t.la = 32'h0a000000 | k;
      t.lp = 16'(port_low + (k % 8));
      t.ra = 32'hc0a80000 ^ (k * 32'h01010101);
      t.rp = 16'(1024 + k);
      return t;
   endfunction

   task automatic test_directed();
      ctwa_pkg::tuple_type ta, tb_, tz;
      ta = '1;
      tz = '0;
      tb_ = '{la: 32'h80000001, lp: 16'h8000, ra: 32'h7fffffff, rp: 16'h0001};
      send_item(ctwa_pkg::MODE_READ, tz, 6'd0);
      send_item(ctwa_pkg::MODE_OBSERVE, tz, 6'd0);
      send_item(ctwa_pkg::MODE_OBSERVE, ta, 6'd63);
      send_item(ctwa_pkg::MODE_OBSERVE, tb_, 6'd0);
      send_item(ctwa_pkg::MODE_OBSERVE, ta, 6'd0);
      send_item(ctwa_pkg::MODE_READ, tz, 6'd1);
      send_item(ctwa_pkg::MODE_READ, tz, 6'd2);
      send_item(ctwa_pkg::MODE_READ, tz, 6'd63);
      send_item(ctwa_pkg::MODE_NONE, ta, 6'd0);
      send_item(ctwa_pkg::MODE_TICK, tz, 6'd0);
      send_item(ctwa_pkg::MODE_TICK, tz, 6'd0);
      send_item(ctwa_pkg::MODE_TICK, tz, 6'd0);
      drain();
      write_csr(ctwa_pkg::CSR_PORT_LOW, 16'd100);
      write_csr(ctwa_pkg::CSR_PORT_HIGH, 16'd200);
      write_csr(ctwa_pkg::CSR_AGE, 16'd0);
      write_csr(ctwa_pkg::CSR_MAX, 16'd2);
      tb_.lp = 16'd99;  send_item(ctwa_pkg::MODE_OBSERVE, tb_, 6'd0);
      tb_.lp = 16'd201; send_item(ctwa_pkg::MODE_OBSERVE, tb_, 6'd0);
      tb_.lp = 16'd100; send_item(ctwa_pkg::MODE_OBSERVE, tb_, 6'd0);
      tb_.lp = 16'd200; send_item(ctwa_pkg::MODE_OBSERVE, tb_, 6'd0);
      tb_.lp = 16'd150; send_item(ctwa_pkg::MODE_OBSERVE, tb_, 6'd0);
      send_item(ctwa_pkg::MODE_READ, tz, 6'd1);
      send_item(ctwa_pkg::MODE_TICK, tz, 6'd0);  // age zero removed by first tick
      drain();
   endtask

   // lower the limit under the count: inserts drop until entries age out
   task automatic test_limit_edges();
      write_csr(ctwa_pkg::CSR_PORT_LOW, 16'd0);
      write_csr(ctwa_pkg::CSR_PORT_HIGH, 16'hffff);
      write_csr(ctwa_pkg::CSR_MAX, 16'h7f);
      write_csr(ctwa_pkg::CSR_AGE, 16'h7f);
      for (int k = 0; k < 66; k++) send_item(ctwa_pkg::MODE_OBSERVE, rand_tuple(), 6'd0);
      send_item(ctwa_pkg::MODE_READ, '0, 6'd63);
      drain();
      write_csr(ctwa_pkg::CSR_MAX, 16'd0);
      send_item(ctwa_pkg::MODE_OBSERVE, rand_tuple(), 6'd0);
      send_item(ctwa_pkg::MODE_OBSERVE, conn_tuple[5], 6'd0);
      drain();
      write_csr(ctwa_pkg::CSR_AGE, 16'd2);
      write_csr(ctwa_pkg::CSR_MAX, 16'd10);
      for (int k = 0; k < 12; k++) send_item(ctwa_pkg::MODE_OBSERVE, rand_tuple(), 6'd0);
      for (int k = 0; k < 3; k++) send_item(ctwa_pkg::MODE_TICK, '0, 6'd0);
      drain();
   endtask

   task automatic test_random(int n, int pct);
      ctwa_pkg::tuple_type t;
      int unsigned r;
      idle_pct = pct;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < 55) begin
            t = pool_tuple($urandom_range(23));
            if ($urandom_range(9) == 0) t.lp = 16'($urandom);
            send_item(ctwa_pkg::MODE_OBSERVE, t, 6'd0);
         end else if (r < 65) send_item(ctwa_pkg::MODE_OBSERVE, rand_tuple(), 6'd0);
         else if (r < 78) send_item(ctwa_pkg::MODE_TICK, rand_tuple(), 6'($urandom));
         else if (r < 97) begin
            send_item(ctwa_pkg::MODE_READ, rand_tuple(),
                      6'($urandom_range(0, conn_count + 2 > 63 ? 63 : conn_count + 2)));
         end else send_item(ctwa_pkg::MODE_NONE, rand_tuple(), 6'($urandom));
      end
      idle_pct = 0;
      drain();
   endtask

   initial begin
      port_low = 16'd0; port_high = 16'hffff; entry_cap = 7'd64; age_reload = 7'd1;
      conn_count = 0; errors = 0; beats = 0; answers_seen = 0; idle_pct = 0;
      hits = 0; inserts = 0; drops = 0; expired = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_limit_edges();
      write_csr(ctwa_pkg::CSR_PORT_LOW, 16'd1000);
      write_csr(ctwa_pkg::CSR_PORT_HIGH, 16'd1005);
      write_csr(ctwa_pkg::CSR_MAX, 16'd16);
      write_csr(ctwa_pkg::CSR_AGE, 16'd3);
      test_random(300, 0);
      write_csr(ctwa_pkg::CSR_MAX, 16'd64);
      write_csr(ctwa_pkg::CSR_AGE, 16'd6);
      test_random(300, 87);
      write_csr(ctwa_pkg::CSR_MAX, 16'd5);
      write_csr(ctwa_pkg::CSR_AGE, 16'd1);
      test_random(300, 10);
      write_csr(ctwa_pkg::CSR_PORT_LOW, 16'hfff0);
      write_csr(ctwa_pkg::CSR_PORT_HIGH, 16'hffff);
      write_csr(ctwa_pkg::CSR_MAX, 16'd100);
      write_csr(ctwa_pkg::CSR_AGE, 16'd127);
      test_random(250, 0);
      drain();
      $display("%0d beats sent, %0d results; %0d inserts, %0d refreshes, %0d drops,",
               beats, answers_seen, inserts, hits, drops);
      $display("%0d entries aged out, over several range, limit and age settings", expired);
      if (errors == 0 && pending_answers.size() == 0) begin
         $display("** connection_table_with_aging: PASSED **");
      end else begin
         $display("** connection_table_with_aging: FAILED **");
      end
      $finish;
   end
endmodule
